@@ hw/rtl/epd_pkg.sv @@
`timescale 1ns / 1ps

package epd_pkg;

  // Field and register widths
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int GAIN_W    = 16;
  localparam int DB_W      = 16;
  localparam int APC_W     = 32;
  localparam int DUTY_W    = 7;
  localparam int ERR_W     = 32;
  localparam int POS_W     = 32;
  localparam int FRAC_W    = 16;

  // Datapath widths
  localparam int MUL_W   = 34;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int DIFF_W  = ERR_W + 1;
  localparam int DGAIN_W = 33;
  localparam int P_W     = 49;
  localparam int INTEG_W = 48;
  localparam int DERIV_W = 62;
  localparam int SUM_W   = 63;
  localparam int MAG_W   = SUM_W - FRAC_W;
  localparam int DIV_W   = 47;

  localparam int DERIV_LIM_LOG2 = 60;
  localparam logic [PROD_W-1:0] DERIV_LIMIT = PROD_W'(1) << DERIV_LIM_LOG2;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 7'd100;

  // Item kinds
  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_DERIV   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_PER_CT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEADBAND     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FLOOR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEILING = 3'd6;

  // Configuration reset values
  localparam logic [GAIN_W-1:0] RST_GAIN_PROP    = 16'd19;
  localparam logic [GAIN_W-1:0] RST_GAIN_INTEG   = 16'd7;
  localparam logic [GAIN_W-1:0] RST_GAIN_DERIV   = 16'd1;
  localparam logic [APC_W-1:0]  RST_ANGLE_PER_CT = 32'd686;
  localparam logic [DB_W-1:0]   RST_DEADBAND     = 16'd1;
  localparam logic [DUTY_W-1:0] RST_DUTY_FLOOR   = 7'd55;
  localparam logic [DUTY_W-1:0] RST_DUTY_CEILING = 7'd80;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ANGLE,
    ST_ERROR,
    ST_PROP,
    ST_INTEG,
    ST_DERIV,
    ST_DIV_WAIT,
    ST_SUM,
    ST_DUTY,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    MUL_ANGLE,
    MUL_DGAIN,
    MUL_PROP,
    MUL_INTEG,
    MUL_DERIV
  } mul_sel_e;

  typedef struct packed {
    logic     count_en;
    logic     load_ref;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     err_en;
    logic     diff_en;
    logic     p_en;
    logic     div_start;
    logic     integ_en;
    logic     sum_en;
    logic     duty_en;
    logic     out_load;
  } epd_ctl_t;

  typedef struct packed {
    logic div_busy;
  } epd_status_t;

endpackage

@@ hw/rtl/epd_divider.sv @@
`timescale 1ns / 1ps

// Divide by the sample rate as a multiply by its reciprocal, 16 reciprocal bits per cycle.
module epd_divider import epd_pkg::*; #(
  parameter int SAMPLE_RATE_HZ = 100
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  output logic [DIV_W-1:0] quotient_o,
  output logic             busy_o
);

  // floor(x / d) == floor(x * ceil(2^s / d) / 2^s) for x < 2^DIV_W, s = DIV_W + clog2(d)
  localparam int SHIFT  = DIV_W + $clog2(SAMPLE_RATE_HZ);
  localparam int RCP_W  = DIV_W + 1;
  localparam int PART_W = 16;
  localparam int PARTS  = (RCP_W + PART_W - 1) / PART_W;
  localparam int ACC_W  = SHIFT + DIV_W;
  localparam int STEP_W = $clog2(PARTS);
  localparam logic [127:0] RCP_FULL =
    ((128'd1 << SHIFT) + 128'(SAMPLE_RATE_HZ) - 128'd1) / 128'(SAMPLE_RATE_HZ);
  localparam logic [PARTS*PART_W-1:0] RECIP = RCP_FULL[PARTS*PART_W-1:0];

  logic [DIV_W-1:0]        x_q;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [STEP_W-1:0]       step_q;
  logic                    busy_q;
  logic [PART_W-1:0]       rcp_part;
  logic [DIV_W+PART_W-1:0] part_prod;

  always_comb begin
    rcp_part  = RECIP[step_q*PART_W +: PART_W];
    part_prod = x_q * rcp_part;
    acc_d     = (acc_q << PART_W) + ACC_W'(part_prod);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= STEP_W'(PARTS - 1);
    end else if (busy_q) begin
      if (step_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  // most significant reciprocal part first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= dividend_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
    end
  end

  assign quotient_o = acc_q[SHIFT +: DIV_W];
  assign busy_o     = busy_q;

endmodule

@@ hw/rtl/epd_datapath.sv @@
`timescale 1ns / 1ps

module epd_datapath import epd_pkg::*; #(
  parameter int SAMPLE_RATE_HZ = 100,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    chan_b_level_i,
  input  logic signed [ERR_W-1:0] reference_i,
  input  epd_ctl_t                ctl_i,
  output epd_status_t             status_o,
  output logic [DUTY_W-1:0]       duty_forward_o,
  output logic [DUTY_W-1:0]       duty_reverse_o,
  output logic signed [POS_W-1:0] position_count_o,
  output logic                    moving_up_o
);

  // Configuration
  logic [GAIN_W-1:0] gain_prop_q, gain_integ_q, gain_deriv_q;
  logic [APC_W-1:0]  apc_q;
  logic [DB_W-1:0]   deadband_q;
  logic [DUTY_W-1:0] floor_q, ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_prop_q  <= RST_GAIN_PROP;
      gain_integ_q <= RST_GAIN_INTEG;
      gain_deriv_q <= RST_GAIN_DERIV;
      apc_q        <= RST_ANGLE_PER_CT;
      deadband_q   <= RST_DEADBAND;
      floor_q      <= RST_DUTY_FLOOR;
      ceil_q       <= RST_DUTY_CEILING;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GAIN_PROP:    gain_prop_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_INTEG:   gain_integ_q <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_DERIV:   gain_deriv_q <= cfg_data_i[GAIN_W-1:0];
        CFG_ANGLE_PER_CT: apc_q        <= cfg_data_i[APC_W-1:0];
        CFG_DEADBAND:     deadband_q   <= cfg_data_i[DB_W-1:0];
        CFG_DUTY_FLOOR:   floor_q      <= cfg_data_i[DUTY_W-1:0];
        CFG_DUTY_CEILING: ceil_q       <= cfg_data_i[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // Loop state
  logic [COUNT_WIDTH-1:0]    count_q;
  logic                      dir_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic signed [ERR_W-1:0]   prev_q;
  logic [DUTY_W-1:0]         fwd_q, rev_q;

  // Working registers
  logic signed [ERR_W-1:0]   ref_q, err_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic [DGAIN_W-1:0]        dgain_q;
  logic [DIFF_W-1:0]         diffmag_q;
  logic                      dneg_q;
  logic signed [P_W-1:0]     p_q;
  logic signed [DERIV_W-1:0] d_q;
  logic signed [SUM_W-1:0]   sum_q;
  logic                      div_neg_q;

  logic [DUTY_W-1:0]         out_fwd_q, out_rev_q;
  logic signed [POS_W-1:0]   out_pos_q;
  logic                      out_dir_q;

  // Shared multiplier
  logic signed [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    unique case (ctl_i.mul_sel)
      MUL_ANGLE: begin
        mul_a = MUL_W'($signed(count_q));
        mul_b = MUL_W'(apc_q);
      end
      MUL_DGAIN: begin
        mul_a = MUL_W'(gain_deriv_q);
        mul_b = MUL_W'(SAMPLE_RATE_HZ);
      end
      MUL_PROP: begin
        mul_a = MUL_W'(gain_prop_q);
        mul_b = MUL_W'(err_q);
      end
      MUL_INTEG: begin
        mul_a = MUL_W'(gain_integ_q);
        mul_b = MUL_W'(prev_q);
      end
      MUL_DERIV: begin
        mul_a = MUL_W'(dgain_q);
        mul_b = MUL_W'(diffmag_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Error: reference minus floor(count * scale), saturated to 32 bits
  logic signed [PROD_W-1:0] angle, err_full;
  logic signed [ERR_W-1:0]  err_sat;

  always_comb begin
    angle    = prod_q >>> FRAC_W;
    err_full = PROD_W'(ref_q) - angle;
    if (err_full[PROD_W-1:ERR_W-1] == '0 || err_full[PROD_W-1:ERR_W-1] == '1) begin
      err_sat = err_full[ERR_W-1:0];
    end else if (err_full[PROD_W-1]) begin
      err_sat = {1'b1, {(ERR_W-1){1'b0}}};
    end else begin
      err_sat = {1'b0, {(ERR_W-1){1'b1}}};
    end
  end

  // Error difference for the derivative term
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        diff_abs;

  always_comb begin
    diff     = DIFF_W'(err_q) - DIFF_W'(prev_q);
    diff_abs = diff[DIFF_W-1] ? -diff : diff;
  end

  // Integral product magnitude feeds the divider
  logic [PROD_W-1:0] prod_abs;
  logic [DIV_W-1:0]  quotient;
  logic              div_busy;

  assign prod_abs = prod_q[PROD_W-1] ? -prod_q : prod_q;

  epd_divider #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_divider (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (ctl_i.div_start),
    .dividend_i(prod_abs[DIV_W-1:0]),
    .quotient_o(quotient),
    .busy_o    (div_busy)
  );

  assign status_o.div_busy = div_busy;

  // Integral update with saturation, derivative clamp
  logic signed [INTEG_W:0]   inc_ext, integ_sum;
  logic signed [INTEG_W-1:0] integ_sat;
  logic [PROD_W-1:0]         d_mag;
  logic signed [DERIV_W-1:0] d_val;

  always_comb begin
    inc_ext   = div_neg_q ? -(INTEG_W+1)'(quotient) : (INTEG_W+1)'(quotient);
    integ_sum = (INTEG_W+1)'(integ_q) + inc_ext;
    if (integ_sum[INTEG_W] == integ_sum[INTEG_W-1]) begin
      integ_sat = integ_sum[INTEG_W-1:0];
    end else if (integ_sum[INTEG_W]) begin
      integ_sat = {1'b1, {(INTEG_W-1){1'b0}}};
    end else begin
      integ_sat = {1'b0, {(INTEG_W-1){1'b1}}};
    end
    d_mag = (prod_q > $signed(DERIV_LIMIT)) ? DERIV_LIMIT : prod_q;
    d_val = dneg_q ? -d_mag[DERIV_W-1:0] : d_mag[DERIV_W-1:0];
  end

  // Duty selection and deadband
  logic [SUM_W-1:0]        sum_abs;
  logic [MAG_W-1:0]        mag;
  logic [DUTY_W-1:0]       duty_pick, duty;
  logic signed [ERR_W:0]   err_ext, db_ext;
  logic                    in_db;

  always_comb begin
    sum_abs = sum_q[SUM_W-1] ? -sum_q : sum_q;
    mag     = sum_abs[SUM_W-1:FRAC_W];
    if (mag > MAG_W'(ceil_q)) begin
      duty_pick = ceil_q;
    end else if (mag < MAG_W'(floor_q)) begin
      duty_pick = floor_q;
    end else begin
      duty_pick = mag[DUTY_W-1:0];
    end
    duty    = (duty_pick > DUTY_MAX) ? DUTY_MAX : duty_pick;
    err_ext = (ERR_W+1)'(err_q);
    db_ext  = (ERR_W+1)'(deadband_q);
    in_db   = (err_ext < db_ext) && (err_ext > -db_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      dir_q   <= 1'b0;
      integ_q <= '0;
      prev_q  <= '0;
      fwd_q   <= '0;
      rev_q   <= '0;
    end else begin
      if (ctl_i.count_en) begin
        dir_q   <= chan_b_level_i;
        count_q <= chan_b_level_i ? count_q + COUNT_WIDTH'(1) : count_q - COUNT_WIDTH'(1);
      end
      if (ctl_i.integ_en) begin
        integ_q <= integ_sat;
        prev_q  <= err_q;
      end
      if (ctl_i.duty_en) begin
        if (in_db) begin
          fwd_q <= '0;
          rev_q <= '0;
        end else if (!err_q[ERR_W-1] && err_q != '0) begin
          fwd_q <= duty;
          rev_q <= '0;
        end else if (err_q[ERR_W-1]) begin
          fwd_q <= '0;
          rev_q <= duty;
        end
        // zero error with zero deadband keeps the previous duties
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_ref) begin
      ref_q <= reference_i;
    end
    if (ctl_i.mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    if (ctl_i.err_en) begin
      err_q <= err_sat;
    end
    if (ctl_i.diff_en) begin
      dgain_q   <= prod_q[DGAIN_W-1:0];
      diffmag_q <= diff_abs;
      dneg_q    <= diff[DIFF_W-1];
    end
    if (ctl_i.p_en) begin
      p_q <= prod_q[P_W-1:0];
    end
    if (ctl_i.div_start) begin
      div_neg_q <= prod_q[PROD_W-1];
    end
    if (ctl_i.integ_en) begin
      d_q <= d_val;
    end
    if (ctl_i.sum_en) begin
      sum_q <= SUM_W'(p_q) + SUM_W'(integ_q) + SUM_W'(d_q);
    end
    if (ctl_i.out_load) begin
      out_fwd_q <= fwd_q;
      out_rev_q <= rev_q;
      out_pos_q <= POS_W'($signed(count_q));
      out_dir_q <= dir_q;
    end
  end

  assign duty_forward_o   = out_fwd_q;
  assign duty_reverse_o   = out_rev_q;
  assign position_count_o = out_pos_q;
  assign moving_up_o      = out_dir_q;

endmodule

@@ hw/rtl/epd_ctrl.sv @@
`timescale 1ns / 1ps

module epd_ctrl import epd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  epd_status_t status_i,
  output epd_ctl_t    ctl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ctl_o      = '0;
    ctl_o.mul_sel = MUL_ANGLE;
    in_ready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (cmd_i == CMD_TICK) begin
            ctl_o.load_ref = 1'b1;
            state_d        = ST_ANGLE;
          end else begin
            ctl_o.count_en = 1'b1;
            state_d        = ST_EMIT;
          end
        end
      end
      ST_ANGLE: begin
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_ANGLE;
        state_d       = ST_ERROR;
      end
      ST_ERROR: begin
        ctl_o.err_en  = 1'b1;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_DGAIN;
        state_d       = ST_PROP;
      end
      ST_PROP: begin
        ctl_o.diff_en = 1'b1;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_PROP;
        state_d       = ST_INTEG;
      end
      ST_INTEG: begin
        ctl_o.p_en    = 1'b1;
        ctl_o.mul_en  = 1'b1;
        ctl_o.mul_sel = MUL_INTEG;
        state_d       = ST_DERIV;
      end
      ST_DERIV: begin
        ctl_o.div_start = 1'b1;
        ctl_o.mul_en    = 1'b1;
        ctl_o.mul_sel   = MUL_DERIV;
        state_d         = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!status_i.div_busy) begin
          ctl_o.integ_en = 1'b1;
          state_d        = ST_SUM;
        end
      end
      ST_SUM: begin
        ctl_o.sum_en = 1'b1;
        state_d      = ST_DUTY;
      end
      ST_DUTY: begin
        ctl_o.duty_en = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    out_valid_d = ctl_o.out_load | (out_valid_q & ~out_ready_i);
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ hw/rtl/encoder_pid_position_drive_unit.sv @@
`timescale 1ns / 1ps
// Encoder edge item: the count steps on acceptance, then the result loads; no new item is taken until it loads.
// Control tick item: accepted only in IDLE, like an edge item, and taken through
//   five shared-multiplier steps, a three-step reciprocal divide by SAMPLE_RATE_HZ, then
//   integral, sum, duty and output steps. A stalled result holds off the next output load.
// Asynchronous active-low reset: count, direction, integral, previous error and both
// duties clear to zero, gains, angle scale and limits return to their defaults, no result pending.
module encoder_pid_position_drive_unit import epd_pkg::*; #(
  parameter int SAMPLE_RATE_HZ = 100,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [CFG_W-1:0]        cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic                    chan_b_level_i,
  input  logic signed [ERR_W-1:0] reference_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [DUTY_W-1:0]       duty_forward_o,
  output logic [DUTY_W-1:0]       duty_reverse_o,
  output logic signed [POS_W-1:0] position_count_o,
  output logic                    moving_up_o
);

  epd_ctl_t    ctl;
  epd_status_t status;

  epd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  epd_datapath #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .chan_b_level_i  (chan_b_level_i),
    .reference_i     (reference_i),
    .ctl_i           (ctl),
    .status_o        (status),
    .duty_forward_o  (duty_forward_o),
    .duty_reverse_o  (duty_reverse_o),
    .position_count_o(position_count_o),
    .moving_up_o     (moving_up_o)
  );

endmodule

@@ hw/rtl/epd_checker.sv @@
`timescale 1ns / 1ps

module epd_checker import epd_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [DUTY_W-1:0]       duty_forward_o,
  input logic [DUTY_W-1:0]       duty_reverse_o,
  input logic signed [POS_W-1:0] position_count_o,
  input logic                    moving_up_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(position_count_o)
      && $stable(duty_forward_o) && $stable(duty_reverse_o) && $stable(moving_up_o))
    else $error("result dropped or changed while stalled");

  // one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accepting an item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_forward_o == '0 || duty_reverse_o == '0)
    else $error("forward and reverse driven together");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> duty_forward_o <= DUTY_MAX && duty_reverse_o <= DUTY_MAX)
    else $error("duty above full scale");

endmodule

bind encoder_pid_position_drive_unit epd_checker u_epd_checker (.*);
